// ===== src/ffba_pkg.sv =====
// Shared types and constants for the first-fit region bump allocator.
// No dependencies; every other file in src refers to this package by scoped name.
package ffba_pkg;

  // Request kinds
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_ALLOC = 2'd1;
  localparam logic [1:0] REQ_ALIGN = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_DROP  = 2'd3;

  // Smallest alignment exponent, and width of the alignment mask (exponent <= 15)
  localparam logic [3:0] MIN_ALIGN_LG = 4'd3;
  localparam int         MASKW        = 16;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] region_base;
    logic [31:0] amount;
    logic [3:0]  align_log2;
  } in_item_t;

  typedef struct packed {
    logic [31:0] address;
    logic [1:0]  status;
    logic [31:0] total_free;
    logic [31:0] lowest_start;
    logic [31:0] highest_end;
  } out_item_t;

  // One table entry as held in the region memory
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
  } entry_t;

  // Decoded request, computed once before the table walk
  typedef struct packed {
    logic             drop;
    logic [31:0]      base;
    logic [31:0]      len;
    logic [31:0]      region_top;
    logic [32:0]      need;
    logic [33:0]      size;
    logic [MASKW-1:0] mask;
  } prep_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DISP,
    S_INS,
    S_PUT,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

// ===== src/ffba_mem.sv =====
// Region table memory: one write port, one read port, registered read data.
// Depends on ffba_pkg for the entry type.
module ffba_mem #(
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  ffba_pkg::entry_t                      wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output ffba_pkg::entry_t                      rd_data
);

  ffba_pkg::entry_t mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rd_data <= mem_r[rd_addr];
  end

endmodule

// ===== src/ffba_prep.sv =====
// Request decode: clips and trims an added region, and forms the byte need,
// rounded size and alignment mask of an allocation. Depends on ffba_pkg.
module ffba_prep (
  input  ffba_pkg::in_item_t req,
  input  logic [31:0]        addr_floor,
  output ffba_pkg::prep_t    prep
);

  logic [32:0]               end_sum;
  logic [31:0]               end_clip;
  logic                      below;
  logic [31:0]               new_base;
  logic [3:0]                lg;
  logic [ffba_pkg::MASKW-1:0] align;
  logic [ffba_pkg::MASKW-1:0] mask;
  logic                      is_align;

  // Clip the region end to the address space, then trim against the address floor
  assign end_sum  = {1'b0, req.region_base} + {1'b0, req.amount};
  assign end_clip = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
  assign below    = req.region_base < addr_floor;
  assign new_base = below ? addr_floor : req.region_base;

  // Alignment, never below the minimum exponent
  assign lg       = (req.align_log2 < ffba_pkg::MIN_ALIGN_LG) ? ffba_pkg::MIN_ALIGN_LG
                                                              : req.align_log2;
  assign align    = ffba_pkg::MASKW'(1) << lg;
  assign mask     = align - ffba_pkg::MASKW'(1);
  assign is_align = (req.req_type == ffba_pkg::REQ_ALIGN);

  always_comb begin
    prep.drop       = below && (end_clip < addr_floor);
    prep.base       = new_base;
    prep.len        = end_clip - new_base;
    prep.region_top = end_clip;
    prep.mask       = mask;
    // Bytes requested before rounding
    prep.need       = {1'b0, req.amount} + (is_align ? {17'b0, mask} : 33'd0);
    // Round up to a multiple of four in the same add
    prep.size       = ({2'b0, req.amount} +
                       (is_align ? {18'b0, align} + 34'd2 : 34'd3)) & ~34'd3;
  end

endmodule

// ===== src/first_fit_region_bump_allocator.sv =====
// First-fit region bump allocator. Keeps up to MAX_REGIONS free regions (base,
// length) in ascending base order in a single-port-write, single-port-read table
// memory. A request is taken only while the block is idle; the result sits in an
// output register so the next request may enter while it waits. An allocate
// goes through the prep and dispatch states, then scans the table entries in
// order until one fits; an add into an occupied table shifts entries up one slot
// at a time from the tail, then writes the new region in place or at the front;
// a dropped or refused add, an add into an empty table and any other request
// go from dispatch straight to the done state. The done state repeats for as
// long as the previous result is still held stalled in the output register. The
// table walk visits one entry per cycle through the memory read port.
// Depends on ffba_pkg, ffba_prep and ffba_mem.
module first_fit_region_bump_allocator #(
  parameter int MAX_REGIONS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ffba_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output ffba_pkg::out_item_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [31:0]         cfg_data
);

  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int SW = 32 + CW;

  ffba_pkg::state_t    state_r, state_nxt;
  ffba_pkg::in_item_t  req_r;
  ffba_pkg::prep_t     prep_c, prep_r;
  logic [31:0]         addr_floor_r;
  logic [CW-1:0]       count_r, count_nxt;
  logic [SW-1:0]       sum_r, sum_nxt;
  logic [31:0]         low_r, low_nxt;
  logic [31:0]         high_r, high_nxt;
  logic [CW-1:0]       pos_r, pos_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [31:0]         addr_r, addr_nxt;
  logic [1:0]          status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  ffba_pkg::out_item_t out_item_r, out_item_nxt;

  logic                mem_we;
  logic [IW-1:0]       mem_waddr;
  ffba_pkg::entry_t    mem_wdata;
  logic [IW-1:0]       mem_raddr;
  ffba_pkg::entry_t    mem_rdata;
  ffba_pkg::entry_t    new_entry;

  logic                in_acc;
  logic                out_free;
  logic [31:0]         free32;
  logic                too_big;
  logic                full;
  logic                is_add;
  logic                is_alloc;
  logic                base_lt;
  logic                fit;
  logic                last_idx;
  logic [CW-1:0]       count_m1;
  logic [CW-1:0]       pos_m1;
  logic [CW-1:0]       pos_m2;
  logic [CW-1:0]       idx_p1;
  logic [31:0]         mask32;
  logic [31:0]         taken_start;
  logic [31:0]         taken_len;

  ffba_prep u_prep (
    .req        (req_r),
    .addr_floor (addr_floor_r),
    .prep       (prep_c)
  );

  ffba_mem #(
    .DEPTH (MAX_REGIONS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // Handshake and shared conditions
  assign in_stall  = (state_r != ffba_pkg::S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign free32    = (|sum_r[SW-1:32]) ? 32'hFFFF_FFFF : sum_r[31:0];
  assign too_big   = prep_r.need > {1'b0, free32};
  assign full      = (count_r == CW'(MAX_REGIONS));
  assign is_add    = (req_r.req_type == ffba_pkg::REQ_ADD);
  assign is_alloc  = (req_r.req_type == ffba_pkg::REQ_ALLOC) ||
                     (req_r.req_type == ffba_pkg::REQ_ALIGN);
  assign base_lt   = prep_r.base < mem_rdata.start;
  assign fit       = {2'b0, mem_rdata.length} >= prep_r.size;
  assign count_m1  = count_r - CW'(1);
  assign pos_m1    = pos_r - CW'(1);
  assign pos_m2    = pos_r - CW'(2);
  assign idx_p1    = idx_r + CW'(1);
  assign last_idx  = (idx_p1 == count_r);
  assign mask32    = {{(32 - ffba_pkg::MASKW){1'b0}}, prep_r.mask};
  assign taken_start = mem_rdata.start + prep_r.size[31:0];
  assign taken_len   = mem_rdata.length - prep_r.size[31:0];

  assign new_entry.start  = prep_r.base;
  assign new_entry.length = prep_r.len;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ffba_pkg::S_IDLE: begin
        if (in_acc) state_nxt = ffba_pkg::S_PREP;
      end
      ffba_pkg::S_PREP: begin
        state_nxt = ffba_pkg::S_DISP;
      end
      ffba_pkg::S_DISP: begin
        if (is_add) begin
          if (prep_r.drop || full || (count_r == '0)) state_nxt = ffba_pkg::S_DONE;
          else state_nxt = ffba_pkg::S_INS;
        end else if (is_alloc) begin
          if (too_big || (count_r == '0)) state_nxt = ffba_pkg::S_DONE;
          else state_nxt = ffba_pkg::S_SCAN;
        end else begin
          state_nxt = ffba_pkg::S_DONE;
        end
      end
      ffba_pkg::S_INS: begin
        if (!base_lt) state_nxt = ffba_pkg::S_DONE;
        else if (pos_r == CW'(1)) state_nxt = ffba_pkg::S_PUT;
      end
      ffba_pkg::S_PUT: begin
        state_nxt = ffba_pkg::S_DONE;
      end
      ffba_pkg::S_SCAN: begin
        if (fit || last_idx) state_nxt = ffba_pkg::S_DONE;
      end
      ffba_pkg::S_DONE: begin
        if (out_free) state_nxt = ffba_pkg::S_IDLE;
      end
      default: state_nxt = ffba_pkg::S_IDLE;
    endcase
  end

  // Datapath controls and register updates
  always_comb begin
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    pos_nxt       = pos_r;
    idx_nxt       = idx_r;
    addr_nxt      = addr_r;
    status_nxt    = status_r;
    mem_we        = 1'b0;
    mem_waddr     = pos_r[IW-1:0];
    mem_wdata     = new_entry;
    mem_raddr     = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;

    case (state_r)
      ffba_pkg::S_DISP: begin
        addr_nxt   = '0;
        status_nxt = ffba_pkg::ST_OK;
        if (is_add) begin
          if (prep_r.drop) begin
            status_nxt = ffba_pkg::ST_DROP;
          end else if (full) begin
            status_nxt = ffba_pkg::ST_FULL;
          end else if (count_r == '0) begin
            // Empty table: store at the front, it is also the tail
            mem_we    = 1'b1;
            mem_waddr = '0;
            count_nxt = count_r + CW'(1);
            sum_nxt   = sum_r + SW'(prep_r.len);
            low_nxt   = prep_r.base;
            high_nxt  = prep_r.region_top;
          end else begin
            mem_raddr = count_m1[IW-1:0];
            pos_nxt   = count_r;
          end
        end else if (is_alloc) begin
          if (too_big || (count_r == '0)) begin
            status_nxt = ffba_pkg::ST_NOFIT;
          end else begin
            mem_raddr = '0;
            idx_nxt   = '0;
          end
        end
      end
      ffba_pkg::S_INS: begin
        if (base_lt) begin
          // Move the entry below up one slot, fetch the next one down
          mem_we    = 1'b1;
          mem_waddr = pos_r[IW-1:0];
          mem_wdata = mem_rdata;
          pos_nxt   = pos_m1;
          mem_raddr = pos_m2[IW-1:0];
        end else begin
          // Place the new region after entries of lower or equal base
          mem_we    = 1'b1;
          mem_waddr = pos_r[IW-1:0];
          count_nxt = count_r + CW'(1);
          sum_nxt   = sum_r + SW'(prep_r.len);
          if (pos_r == count_r) high_nxt = prep_r.region_top;
        end
      end
      ffba_pkg::S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        count_nxt = count_r + CW'(1);
        sum_nxt   = sum_r + SW'(prep_r.len);
        low_nxt   = prep_r.base;
      end
      ffba_pkg::S_SCAN: begin
        if (fit) begin
          // Bump the first region that holds the rounded size
          mem_we           = 1'b1;
          mem_waddr        = idx_r[IW-1:0];
          mem_wdata.start  = taken_start;
          mem_wdata.length = taken_len;
          sum_nxt          = sum_r - SW'(prep_r.size);
          if (idx_r == '0) low_nxt = taken_start;
          if (req_r.req_type == ffba_pkg::REQ_ALIGN) begin
            addr_nxt = (mem_rdata.start + mask32) & ~mask32;
          end else begin
            addr_nxt = mem_rdata.start;
          end
        end else if (last_idx) begin
          status_nxt = ffba_pkg::ST_NOFIT;
        end else begin
          idx_nxt   = idx_p1;
          mem_raddr = idx_p1[IW-1:0];
        end
      end
      ffba_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_item_nxt.address      = addr_r;
          out_item_nxt.status       = status_r;
          out_item_nxt.total_free   = free32;
          out_item_nxt.lowest_start = low_r;
          out_item_nxt.highest_end  = high_r;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ffba_pkg::S_IDLE;
      addr_floor_r <= '0;
      count_r      <= '0;
      sum_r        <= '0;
      low_r        <= '0;
      high_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) addr_floor_r <= cfg_data;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) req_r <= in_item;
    if (state_r == ffba_pkg::S_PREP) prep_r <= prep_c;
    pos_r      <= pos_nxt;
    idx_r      <= idx_nxt;
    addr_r     <= addr_nxt;
    status_r   <= status_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule
